### hw/rtl/hhpid_pkg.sv
package hhpid_pkg;

  // Field widths
  localparam int unsigned AngleW = 16;
  localparam int unsigned GainW  = 24;
  localparam int unsigned DriveW = 15;
  localparam int unsigned SumW   = 32;
  localparam int unsigned DiffW  = AngleW + 1;
  localparam int unsigned OutW   = 16;

  // Product widths
  localparam int unsigned PropW  = GainW + AngleW;
  localparam int unsigned IntW   = GainW + SumW;
  localparam int unsigned DerW   = GainW + DiffW;
  localparam int unsigned AccW   = IntW + 2;
  localparam int unsigned PidW   = AccW - 16;
  localparam int unsigned MixW   = PidW + 1;

  // Configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 24;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TARGET_HEADING = 3'd0,
    REG_KP_GAIN        = 3'd1,
    REG_KI_GAIN        = 3'd2,
    REG_KD_GAIN        = 3'd3,
    REG_BASE_DRIVE     = 3'd4,
    REG_DRIVE_LIMIT    = 3'd5
  } cfg_reg_t;

  // Reset values of the drive registers (Q7.8: 8.5 and 40.0)
  localparam logic signed [DriveW-1:0] BaseDriveReset  = 15'sd2176;
  localparam logic        [DriveW-1:0] DriveLimitReset = 15'd10240;

  // Error stage result
  typedef struct packed {
    logic signed [AngleW-1:0] err;
    logic signed [DiffW-1:0]  diff;
    logic signed [SumW-1:0]   sum;
  } err_t;

  // Product stage result
  typedef struct packed {
    logic signed [AngleW-1:0] err;
    logic signed [PropW-1:0]  prop;
    logic signed [IntW-1:0]   integ;
    logic signed [DerW-1:0]   deriv;
  } prod_t;

endpackage

### hw/rtl/hhpid_err.sv
module hhpid_err (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic        [hhpid_pkg::AngleW-1:0] sample,
  input  logic        [hhpid_pkg::AngleW-1:0] target,
  output logic                             out_valid,
  input  logic                             out_ready,
  output hhpid_pkg::err_t                  out_data
);
  import hhpid_pkg::*;

  logic                      valid;
  err_t                      data;
  logic signed [SumW-1:0]    error_sum;
  logic signed [AngleW-1:0]  prior_error;

  logic                      take;
  logic signed [AngleW-1:0]  err_next;
  logic signed [DiffW-1:0]   diff_next;
  logic signed [SumW:0]      sum_wide;
  logic signed [SumW-1:0]    error_sum_next;

  assign in_ready = !valid || out_ready;
  assign take     = in_valid && in_ready;

  // Shortest error (the 16-bit wrap of the difference), its change and the saturating sum
  always_comb begin
    err_next  = signed'(sample - target);
    diff_next = DiffW'(err_next) - DiffW'(prior_error);
    sum_wide  = (SumW+1)'(error_sum) + (SumW+1)'(err_next);
    if (sum_wide[SumW] != sum_wide[SumW-1]) begin
      error_sum_next = sum_wide[SumW] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
    end else begin
      error_sum_next = sum_wide[SumW-1:0];
    end
  end

  // Integrator and previous error move on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum   <= '0;
      prior_error <= '0;
      valid       <= 1'b0;
    end else begin
      if (take) begin
        error_sum   <= error_sum_next;
        prior_error <= err_next;
      end
      if (in_ready) begin
        valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      data.err  <= err_next;
      data.diff <= diff_next;
      data.sum  <= error_sum_next;
    end
  end

  assign out_valid = valid;
  assign out_data  = data;

endmodule

### hw/rtl/hhpid_mul.sv
module hhpid_mul (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  hhpid_pkg::err_t                     in_data,
  input  logic signed [hhpid_pkg::GainW-1:0]  kp,
  input  logic signed [hhpid_pkg::GainW-1:0]  ki,
  input  logic signed [hhpid_pkg::GainW-1:0]  kd,
  output logic                                out_valid,
  input  logic                                out_ready,
  output hhpid_pkg::prod_t                    out_data
);
  import hhpid_pkg::*;

  logic  valid;
  prod_t data;
  logic  take;

  assign in_ready = !valid || out_ready;
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  // Three independent gain products
  always_ff @(posedge clk) begin
    if (take) begin
      data.err   <= in_data.err;
      data.prop  <= PropW'(kp) * PropW'(in_data.err);
      data.integ <= IntW'(ki) * IntW'(in_data.sum);
      data.deriv <= DerW'(kd) * DerW'(in_data.diff);
    end
  end

  assign out_valid = valid;
  assign out_data  = data;

endmodule

### hw/rtl/hhpid_mix.sv
module hhpid_mix (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  hhpid_pkg::prod_t                     in_data,
  input  logic signed [hhpid_pkg::DriveW-1:0]  base,
  input  logic        [hhpid_pkg::DriveW-1:0]  limit,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [hhpid_pkg::OutW-1:0]    left,
  output logic signed [hhpid_pkg::OutW-1:0]    right,
  output logic signed [hhpid_pkg::AngleW-1:0]  err
);
  import hhpid_pkg::*;

  logic                    valid;
  logic                    take;
  logic signed [AccW-1:0]  acc;
  logic signed [PidW-1:0]  pid;
  logic signed [MixW-1:0]  lim_pos;
  logic signed [MixW-1:0]  lim_neg;
  logic signed [MixW-1:0]  left_raw;
  logic signed [MixW-1:0]  right_raw;
  logic signed [OutW-1:0]  left_next;
  logic signed [OutW-1:0]  right_next;

  assign in_ready = !valid || out_ready;
  assign take     = in_valid && in_ready;

  // Sum of terms, arithmetic shift to Q8.8, then base +/- PID with clamp
  always_comb begin
    acc       = AccW'(in_data.prop) + AccW'(in_data.integ) + AccW'(in_data.deriv);
    pid       = acc[AccW-1:16];
    lim_pos   = signed'({{(MixW-DriveW){1'b0}}, limit});
    lim_neg   = -lim_pos;
    left_raw  = MixW'(base) + MixW'(pid);
    right_raw = MixW'(base) - MixW'(pid);

    if (left_raw > lim_pos) begin
      left_next = lim_pos[OutW-1:0];
    end else if (left_raw < lim_neg) begin
      left_next = lim_neg[OutW-1:0];
    end else begin
      left_next = left_raw[OutW-1:0];
    end

    if (right_raw > lim_pos) begin
      right_next = lim_pos[OutW-1:0];
    end else if (right_raw < lim_neg) begin
      right_next = lim_neg[OutW-1:0];
    end else begin
      right_next = right_raw[OutW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      left  <= left_next;
      right <= right_next;
      err   <= in_data.err;
    end
  end

  assign out_valid = valid;

endmodule

### hw/rtl/heading_hold_pid_differential_drive.sv
// Channel   | Dir | Transfer when          | Payload
// s_axis    | in  | s_tvalid & s_tready    | tdata[15:0] roll_sample
// m_axis    | out | m_tvalid & m_tready    | tdata[15:0] left, [31:16] right, [47:32] error
// cfg       | in  | cfg_valid & cfg_ready  | cfg_index register, cfg_data value
//
// Three-stage pipeline (error/integral, gain products, mix/clamp): one sample
// per cycle while m_tready allows; each result passes the error, product and mix registers.
// Integrator and previous error update at the input transfer.
// Reset clears integrator, previous error and gains; base and limit go to 8.5/40.0.
// Each stage holds its item under back-pressure; the input side keeps taking
// samples while any stage is empty.
// cfg_ready is low while any sample is in the pipeline or s_tvalid is high.
module heading_hold_pid_differential_drive (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [15:0]                          s_tdata,  // [15:0] roll_sample
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [47:0]                          m_tdata,  // [15:0] left_drive,
                                                         // [31:16] right_drive,
                                                         // [47:32] heading_error
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [hhpid_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [hhpid_pkg::CfgDataW-1:0]       cfg_data
);
  import hhpid_pkg::*;

  logic        [AngleW-1:0] target_heading;
  logic signed [GainW-1:0]  kp_gain;
  logic signed [GainW-1:0]  ki_gain;
  logic signed [GainW-1:0]  kd_gain;
  logic signed [DriveW-1:0] base_drive;
  logic        [DriveW-1:0] drive_limit;

  logic  e2m_valid;
  logic  e2m_ready;
  logic  m2x_valid;
  logic  m2x_ready;
  err_t  err_data;
  prod_t prod_data;

  logic signed [OutW-1:0]   left;
  logic signed [OutW-1:0]   right;
  logic signed [AngleW-1:0] err;

  // Register writes only with the pipeline empty and no sample on offer
  assign cfg_ready = !(e2m_valid || m2x_valid || m_tvalid || s_tvalid);

  // Register file
  always_ff @(posedge clk) begin
    if (rst) begin
      target_heading <= '0;
      kp_gain        <= '0;
      ki_gain        <= '0;
      kd_gain        <= '0;
      base_drive     <= BaseDriveReset;
      drive_limit    <= DriveLimitReset;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TARGET_HEADING: target_heading <= cfg_data[AngleW-1:0];
        REG_KP_GAIN:        kp_gain        <= signed'(cfg_data[GainW-1:0]);
        REG_KI_GAIN:        ki_gain        <= signed'(cfg_data[GainW-1:0]);
        REG_KD_GAIN:        kd_gain        <= signed'(cfg_data[GainW-1:0]);
        REG_BASE_DRIVE:     base_drive     <= signed'(cfg_data[DriveW-1:0]);
        REG_DRIVE_LIMIT:    drive_limit    <= cfg_data[DriveW-1:0];
        default: ;
      endcase
    end
  end

  hhpid_err u_err (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .sample    (s_tdata[AngleW-1:0]),
    .target    (target_heading),
    .out_valid (e2m_valid),
    .out_ready (e2m_ready),
    .out_data  (err_data)
  );

  hhpid_mul u_mul (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (e2m_valid),
    .in_ready  (e2m_ready),
    .in_data   (err_data),
    .kp        (kp_gain),
    .ki        (ki_gain),
    .kd        (kd_gain),
    .out_valid (m2x_valid),
    .out_ready (m2x_ready),
    .out_data  (prod_data)
  );

  hhpid_mix u_mix (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (m2x_valid),
    .in_ready  (m2x_ready),
    .in_data   (prod_data),
    .base      (base_drive),
    .limit     (drive_limit),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .left      (left),
    .right     (right),
    .err       (err)
  );

  assign m_tdata = {err, right, left};

endmodule
